// ===== sv/pcbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the prefix-code bit packer.
// Depends on nothing; every other file imports it.
package pcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int TABLE_DEPTH      = 256;
  localparam int CODE_W           = 32;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        symbol;
    logic [5:0]        code_length;
    logic [CODE_W-1:0] code_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

endpackage

// ===== sv/prefix_code_bit_packer.sv =====
`timescale 1ns / 1ps
// Top level of the prefix-code bit packer; instantiates front, queue and back.
// Uses pcbp_pkg.

// Prefix-code packer. Load items write a 256-entry code table (length
// saturated to MAX_CODE_LEN, code masked to its length; the table starts
// empty so an unloaded symbol adds nothing). Encode items append the code,
// first bit first, to a bit accumulator and each full byte leaves as one
// result transfer; finish flushes a partial byte left-aligned and then a
// trailer byte of 8 minus the leftover bit count. The last byte caused by an
// item carries last. Timing: the front end takes one item per cycle while
// the queue has room and classifies it in a two-stage lookup (registered
// table read, then the splice onto the leftover bits). Bytes go out one
// per cycle from the back end while result_ready is high; an encode with
// n bytes sends n of them and a finish one or two, and an encode yields at
// most (MAX_CODE_LEN+7)/8 bytes (four at the default). A two-job queue
// sits between the lookup and the output register, so new items keep being
// taken while a byte waits for result_ready, until the queue fills. An
// item's first byte passes the lookup, a queue slot and the back end.
module prefix_code_bit_packer import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_ready,
  output result_t result,
  output logic    result_valid,
  input  logic    result_ready
);

  localparam int ACC_W     = MAX_CODE_LEN + 7;
  localparam int JOB_W     = (ACC_W > 16) ? ACC_W : 16;
  localparam int MAX_BYTES = ((MAX_CODE_LEN + 7) / 8 > 2) ? (MAX_CODE_LEN + 7) / 8 : 2;
  localparam int NB_W      = $clog2(MAX_BYTES + 1);

  logic                  push_valid;
  logic                  push_ready;
  logic [JOB_W-1:0]      push_data;
  logic [NB_W-1:0]       push_nbytes;
  logic                  job_valid;
  logic                  job_ready;
  logic [JOB_W+NB_W-1:0] job;

  pcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .JOB_W       (JOB_W),
    .NB_W        (NB_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .push_nbytes(push_nbytes)
  );

  pcbp_queue #(
    .WIDTH(JOB_W + NB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_data, push_nbytes}),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_data  (job)
  );

  pcbp_back #(
    .JOB_W(JOB_W),
    .NB_W (NB_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .result      (result),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

endmodule

// ===== sv/pcbp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, owns the code table and the bit accumulator,
// and turns each encode or finish into a byte job for the queue. Uses pcbp_pkg.
module pcbp_front import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int JOB_W        = 39,
  parameter int NB_W         = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic             item_valid,
  output logic             item_ready,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [JOB_W-1:0] push_data,
  output logic [NB_W-1:0]  push_nbytes
);

  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int ACC_W = MAX_CODE_LEN + 7;
  localparam int TOT_W = $clog2(MAX_CODE_LEN + 8);
  localparam int ENT_W = LEN_W + CODE_W;

  logic                   accept;
  logic [LEN_W-1:0]       len_sat;
  logic [CODE_W-1:0]      code_masked;

  logic [ENT_W-1:0]       entry_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic                   s1_valid;
  logic [1:0]             s1_op;
  logic                   rd_valid;
  logic [ENT_W-1:0]       rd_entry;

  logic [6:0]             pend_bits;
  logic [2:0]             pend_count;

  logic [LEN_W-1:0]       len;
  logic [CODE_W-1:0]      code;
  logic [ACC_W-1:0]       acc;
  logic [TOT_W-1:0]       total;
  logic [NB_W-1:0]        enc_nbytes;
  logic [7:0]             flush_byte;
  logic [7:0]             trailer;
  logic                   need_push;
  logic                   advance;

  assign accept = item_valid && item_ready;

  // Saturate the length and keep only the low code_length bits of the code.
  always_comb begin
    if (item.code_length > 6'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = LEN_W'(item.code_length);
    end
    for (int i = 0; i < CODE_W; i++) begin
      code_masked[i] = item.code_bits[i] && (i < int'(len_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_LOAD) begin
      entry_mem[item.symbol] <= {len_sat, code_masked};
    end
    if (accept) begin
      rd_entry <= entry_mem[item.symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else if (accept) begin
      rd_valid <= entry_valid[item.symbol];
      if (item.opcode == OP_LOAD) begin
        entry_valid[item.symbol] <= 1'b1;
      end
    end
  end

  // Second stage: splice the code onto the leftover bits.
  always_comb begin
    len        = rd_valid ? rd_entry[ENT_W-1:CODE_W] : '0;
    code       = rd_valid ? rd_entry[CODE_W-1:0] : '0;
    acc        = (ACC_W'(pend_bits) << len) | ACC_W'(code);
    total      = TOT_W'(pend_count) + TOT_W'(len);
    enc_nbytes = NB_W'(total >> 3);
    flush_byte = 8'({1'b0, pend_bits} << (4'd8 - {1'b0, pend_count}));
    trailer    = 8'(4'd8 - {1'b0, pend_count});

    push_data   = '0;
    push_nbytes = '0;
    need_push   = 1'b0;
    case (s1_op)
      OP_ENCODE: begin
        push_data   = JOB_W'(acc >> total[2:0]);
        push_nbytes = enc_nbytes;
        need_push   = (enc_nbytes != '0);
      end
      OP_FINISH: begin
        need_push = 1'b1;
        if (pend_count != 3'd0) begin
          push_data   = JOB_W'({flush_byte, trailer});
          push_nbytes = NB_W'(2);
        end else begin
          push_data   = JOB_W'(trailer);
          push_nbytes = NB_W'(1);
        end
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign push_valid = s1_valid && need_push;
  assign advance    = s1_valid && (!need_push || push_ready);
  assign item_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_op    <= OP_LOAD;
    end else if (item_ready) begin
      s1_valid <= item_valid &&
                  (item.opcode == OP_ENCODE || item.opcode == OP_FINISH);
      s1_op    <= item.opcode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else if (advance) begin
      if (s1_op == OP_ENCODE) begin
        pend_bits  <= acc[6:0] & 7'((8'd1 << total[2:0]) - 8'd1);
        pend_count <= total[2:0];
      end else if (s1_op == OP_FINISH) begin
        pend_bits  <= '0;
        pend_count <= '0;
      end
    end
  end

endmodule

// ===== sv/pcbp_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Uses pcbp_pkg for its depth.
module pcbp_queue import pcbp_pkg::*; #(
  parameter int WIDTH = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/pcbp_back.sv =====
`timescale 1ns / 1ps
// Back end: takes byte jobs from the queue and sends one byte per transfer,
// most significant first, flagging the last. Uses pcbp_pkg.
module pcbp_back import pcbp_pkg::*; #(
  parameter int JOB_W = 39,
  parameter int NB_W  = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  logic [JOB_W+NB_W-1:0] job,
  output result_t               result,
  output logic                  result_valid,
  input  logic                  result_ready
);

  logic [JOB_W-1:0] data;
  logic [NB_W-1:0]  remaining;
  logic [JOB_W-1:0] shifted;
  logic             sent;

  assign result_valid = (remaining != '0);
  assign sent         = result_valid && result_ready;
  assign job_ready    = (remaining == '0) || (remaining == NB_W'(1) && result_ready);
  assign shifted      = data >> {remaining - 1'b1, 3'b000};

  always_comb begin
    result.out_byte = shifted[7:0];
    result.last     = (remaining == NB_W'(1));
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      data <= job[JOB_W+NB_W-1:NB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (job_valid && job_ready) begin
      remaining <= job[NB_W-1:0];
    end else if (sent) begin
      remaining <= remaining - 1'b1;
    end
  end

endmodule

// ===== sv/pcbp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the prefix-code bit packer, bound to the top level.
// Uses pcbp_pkg.
module pcbp_checker import pcbp_pkg::*; (
  input logic    clk,
  input logic    rst,
  input item_t   item,
  input logic    item_valid,
  input logic    item_ready,
  input result_t result,
  input logic    result_valid,
  input logic    result_ready
);

  // Held byte must not change under back-pressure.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // A waiting input transfer keeps its payload until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("input item changed while waiting");

  // Nothing comes out right after reset.
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Front end is empty after reset, so it takes an item at once.
  a_rst_ready: assert property (@(posedge clk)
    rst |=> item_ready)
    else $error("not ready after reset");

  // A byte without last is always followed straight away by another byte.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result.last |=> result_valid)
    else $error("byte run broken before last");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (
  .clk         (clk),
  .rst         (rst),
  .item        (item),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .result      (result),
  .result_valid(result_valid),
  .result_ready(result_ready)
);
